// ===== design/gdma_pkg.sv =====
// shared widths, register codes, constants and controller/datapath structs
package gdma_pkg;

  localparam int GAS_W     = 31;
  localparam int HUM_W     = 17;
  localparam int LVL_W     = 16;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MAX     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_THRESHOLD = 8'd1;

  localparam logic [LVL_W-1:0] LEVEL_MAX_RST = 16'd1000;
  localparam logic [LVL_W-1:0] LED_THR_RST   = 16'd100;

  // divide by ten: multiply by ceil(2^35 / 10), exact for any 32-bit operand
  localparam int               DIV10_MAGIC_W = 32;
  localparam logic [31:0]      DIV10_MAGIC   = 32'hCCCC_CCCD;
  localparam int               DIV10_SHIFT   = 35;
  localparam int               PROD_W        = GAS_W + DIV10_MAGIC_W;
  localparam int               LRAW_W        = PROD_W - DIV10_SHIFT;

  typedef struct packed {
    logic load;
    logic update;
    logic div_start;
    logic diff;
    logic mul;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_sts_t;

endpackage

// ===== design/gdma_div.sv =====
// divider by a constant: reciprocal multiplication in two partial-product steps
module gdma_div #(
  parameter int VAL_W   = 31,
  parameter int DIVD_W  = 35,
  parameter int DIVISOR = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  output logic              busy_o,
  output logic [VAL_W-1:0]  quotient_o
);

  // floor(x * m / 2^SH) equals floor(x / DIVISOR) for every x below 2^DIVD_W
  localparam int SH   = DIVD_W + $clog2(DIVISOR);
  localparam int MW   = DIVD_W + 1;
  localparam int LO_W = (MW + 1) / 2;
  localparam int HI_W = MW - LO_W;
  localparam int PPW  = DIVD_W + LO_W;
  localparam int AW   = SH + VAL_W;

  localparam longint unsigned MAGIC_VAL =
    ((64'd1 << SH) + 64'(DIVISOR - 1)) / 64'(DIVISOR);
  localparam logic [MW-1:0]   MAGIC    = MW'(MAGIC_VAL);
  localparam logic [LO_W-1:0] MAGIC_LO = MAGIC[LO_W-1:0];
  localparam logic [HI_W-1:0] MAGIC_HI = MAGIC[MW-1:LO_W];

  localparam logic [1:0] STEP_LO = 2'd2;
  localparam logic [1:0] STEP_HI = 2'd1;

  logic [1:0]        step_q;
  logic [DIVD_W-1:0] x_q;
  logic [AW-1:0]     acc_q;
  logic [LO_W-1:0]   mult_b;
  logic [PPW-1:0]    pp;

  // one narrow multiplier shared by the low and high halves of the reciprocal
  assign mult_b = (step_q == STEP_LO) ? MAGIC_LO : LO_W'(MAGIC_HI);
  assign pp     = PPW'(x_q) * PPW'(mult_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (start_i) begin
      step_q <= STEP_LO;
    end else if (step_q != '0) begin
      step_q <= step_q - 1'b1;
    end
  end

  // the full product stays below 2^AW, so the sum never loses a carry
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= dividend_i;
    end
    if (step_q == STEP_LO) begin
      acc_q <= AW'(pp);
    end else if (step_q == STEP_HI) begin
      acc_q <= acc_q + (AW'(pp) << LO_W);
    end
  end

  assign busy_o     = (step_q != '0);
  assign quotient_o = acc_q[AW-1:SH];

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (step_q == '0)) else $error("divider restarted while busy");
  a_start_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> (step_q == STEP_LO)) else $error("divider step not loaded");
  a_step_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((step_q == STEP_LO) && !start_i) |=> (step_q == STEP_HI))
    else $error("divider steps out of order");

endmodule

// ===== design/gdma_datapath.sv =====
// sample rings, running sums, average dividers, deviation and output registers
module gdma_datapath #(
  parameter int WINDOW_LEN = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gdma_pkg::dp_cmd_t                 cmd_i,
  output gdma_pkg::dp_sts_t                 sts_o,
  input  logic                              cfg_we_i,
  input  logic [gdma_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gdma_pkg::LVL_W-1:0]        cfg_data_i,
  input  logic [gdma_pkg::GAS_W-1:0]        gas_sample_i,
  input  logic [gdma_pkg::HUM_W-1:0]        humidity_sample_i,
  output logic [gdma_pkg::LVL_W-1:0]        deviation_level_o,
  output logic [gdma_pkg::LVL_W-1:0]        led_duty_o,
  output logic [gdma_pkg::HUM_W-1:0]        humidity_average_o,
  output logic [gdma_pkg::GAS_W-1:0]        gas_average_o
);
  import gdma_pkg::*;

  localparam int PW  = $clog2(WINDOW_LEN);
  localparam int GSW = GAS_W + $clog2(WINDOW_LEN);
  localparam int HSW = HUM_W + $clog2(WINDOW_LEN);
  localparam int GAW = GAS_W + $clog2(WINDOW_LEN + 1);
  localparam int HAW = HUM_W + $clog2(WINDOW_LEN + 1);

  logic [GAS_W-1:0]      gas_ring_q [WINDOW_LEN];
  logic [HUM_W-1:0]      hum_ring_q [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] valid_q;
  logic [PW-1:0]         pos_q;

  logic [LVL_W-1:0]  level_max_q, led_thr_q;
  logic [GAS_W-1:0]  gas_smp_q, rd_gas_q;
  logic [HUM_W-1:0]  hum_smp_q, rd_hum_q;
  logic              rd_vld_q;
  logic [GSW-1:0]    gas_sum_q;
  logic [HSW-1:0]    hum_sum_q;
  logic [GAS_W-1:0]  gas_avg_q;
  logic [HUM_W-1:0]  hum_avg_q;
  logic [GAS_W-1:0]  diff_q;
  logic [PROD_W-1:0] prod_q;

  logic [GAS_W-1:0]  old_gas;
  logic [HUM_W-1:0]  old_hum;
  logic [GAW-1:0]    gas_acc;
  logic [HAW-1:0]    hum_acc;
  logic [GAS_W-1:0]  gas_quo;
  logic [HUM_W-1:0]  hum_quo;
  logic              gas_busy, hum_busy;
  logic [LRAW_W-1:0] level_raw;
  logic [LVL_W-1:0]  level;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_max_q <= LEVEL_MAX_RST;
      led_thr_q   <= LED_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LEVEL_MAX:     level_max_q <= cfg_data_i;
        CFG_LED_THRESHOLD: led_thr_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ring storage: registered read of the entry about to be replaced
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_gas_q <= gas_ring_q[pos_q];
      rd_hum_q <= hum_ring_q[pos_q];
    end
    if (cmd_i.update) begin
      gas_ring_q[pos_q] <= gas_smp_q;
      hum_ring_q[pos_q] <= hum_smp_q;
    end
  end

  // an entry never written reads as zero
  assign old_gas = rd_vld_q ? rd_gas_q : '0;
  assign old_hum = rd_vld_q ? rd_hum_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rd_vld_q  <= 1'b0;
      pos_q     <= '0;
      gas_sum_q <= '0;
      hum_sum_q <= '0;
      gas_avg_q <= '0;
      hum_avg_q <= '0;
    end else begin
      if (cmd_i.load) begin
        rd_vld_q <= valid_q[pos_q];
      end
      if (cmd_i.update) begin
        valid_q[pos_q] <= 1'b1;
        pos_q          <= (pos_q == PW'(WINDOW_LEN - 1)) ? '0 : pos_q + 1'b1;
        // running window sum: drop the replaced entry, add the new sample
        gas_sum_q <= gas_sum_q - GSW'(old_gas) + GSW'(gas_smp_q);
        hum_sum_q <= hum_sum_q - HSW'(old_hum) + HSW'(hum_smp_q);
      end
      if (cmd_i.diff) begin
        gas_avg_q <= gas_quo;
        hum_avg_q <= hum_quo;
      end
    end
  end

  assign gas_acc = GAW'(gas_avg_q) + GAW'(gas_sum_q);
  assign hum_acc = HAW'(hum_avg_q) + HAW'(hum_sum_q);

  gdma_div #(
    .VAL_W   (GAS_W),
    .DIVD_W  (GAW),
    .DIVISOR (WINDOW_LEN + 1)
  ) u_gas_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (gas_acc),
    .busy_o     (gas_busy),
    .quotient_o (gas_quo)
  );

  gdma_div #(
    .VAL_W   (HUM_W),
    .DIVD_W  (HAW),
    .DIVISOR (WINDOW_LEN + 1)
  ) u_hum_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (hum_acc),
    .busy_o     (hum_busy),
    .quotient_o (hum_quo)
  );

  assign sts_o.div_busy = gas_busy | hum_busy;

  assign level_raw = prod_q[PROD_W-1:DIV10_SHIFT];
  always_comb begin
    if (level_raw > LRAW_W'(level_max_q)) begin
      level = level_max_q;
    end else begin
      level = level_raw[LVL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      gas_smp_q <= gas_sample_i;
      hum_smp_q <= humidity_sample_i;
    end
    if (cmd_i.diff) begin
      diff_q <= (gas_smp_q >= gas_quo) ? (gas_smp_q - gas_quo) : (gas_quo - gas_smp_q);
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(diff_q) * PROD_W'(DIV10_MAGIC);
    end
    if (cmd_i.fin) begin
      deviation_level_o  <= level;
      led_duty_o         <= (level > led_thr_q) ? level : '0;
      humidity_average_o <= hum_avg_q;
      gas_average_o      <= gas_avg_q;
    end
  end

  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PW'(WINDOW_LEN - 1)) else $error("ring position out of range");
  a_entry_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> valid_q[$past(pos_q)]) else $error("written ring entry not marked");
  a_level_clamp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin |=> (deviation_level_o <= $past(level_max_q)))
    else $error("level above clamp");
  a_duty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin |=> ((led_duty_o == '0) || (led_duty_o == deviation_level_o)))
    else $error("led duty neither zero nor level");

endmodule

// ===== design/gdma_ctrl.sv =====
// sequencing state machine: steps one request through the datapath
module gdma_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output gdma_pkg::dp_cmd_t cmd_o,
  input  gdma_pkg::dp_sts_t sts_i
);
  import gdma_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_DSTART,
    ST_DWAIT,
    ST_DIFF,
    ST_MUL,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = ST_DSTART;
      end
      ST_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (!sts_i.div_busy) begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_FIN;
      end
      ST_FIN: begin
        // wait here until the output register can take the result
        if (slot_free) begin
          cmd_o.fin   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_div_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !sts_i.div_busy) else $error("divider started while busy");
  a_fin_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin |-> slot_free) else $error("result overwrites a pending one");
  a_accept_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_UPD))
    else $error("accepted request not sequenced");

endmodule

// ===== design/gas_deviation_from_moving_average.sv =====
// top level: gas deviation from moving average, controller plus datapath
//
// Input channel in_valid_i / in_stall_o carries one gas sample and one humidity
// sample per request; a request is taken when in_valid_i is high and in_stall_o
// is low. Output channel out_valid_o / out_stall_i returns one result per request:
// clamped deviation level, LED duty, and the updated humidity and gas averages.
// Configuration writes use cfg_valid_i / cfg_ready_o with cfg_index_i selecting
// level_max (0) or led_threshold (1); other indexes are ignored. Write only
// while no request is in flight.
// A request steps through load, ring update, divider start and wait, difference,
// multiply and finish; no new request is taken until the controller is idle. Both
// averages divide by WINDOW_LEN + 1 through a reciprocal multiply done as two
// partial products; the deviation then needs a compare, a divide by ten and the
// output register. Reset clears the ring valid flags (unwritten entries read as
// zero), the ring position and both averages, and sets level_max to 1000 and
// led_threshold to 100. A stalled result stays in the output register; the next
// request is still accepted and runs until its result is ready, then waits for it.
module gas_deviation_from_moving_average #(
  parameter int WINDOW_LEN = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [gdma_pkg::GAS_W-1:0]     gas_sample_i,
  input  logic [gdma_pkg::HUM_W-1:0]     humidity_sample_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [gdma_pkg::LVL_W-1:0]     deviation_level_o,
  output logic [gdma_pkg::LVL_W-1:0]     led_duty_o,
  output logic [gdma_pkg::HUM_W-1:0]     humidity_average_o,
  output logic [gdma_pkg::GAS_W-1:0]     gas_average_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gdma_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gdma_pkg::LVL_W-1:0]     cfg_data_i
);
  import gdma_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  gdma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  gdma_datapath #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_valid_i && cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .gas_sample_i       (gas_sample_i),
    .humidity_sample_i  (humidity_sample_i),
    .deviation_level_o  (deviation_level_o),
    .led_duty_o         (led_duty_o),
    .humidity_average_o (humidity_average_o),
    .gas_average_o      (gas_average_o)
  );

endmodule
